/* design/lcdfb_pkg.sv */
// Shared constants, command codes and store request type for the LCD framebuffer text engine.
`default_nettype none

package lcdfb_pkg;

   localparam int SCREEN_COLUMNS = 84;
   localparam int SCREEN_ROWS    = 48;
   localparam int GLYPH_WIDTH    = 5;
   localparam int GLYPH_HEIGHT   = 7;

   localparam int STORE_BYTES    = ((SCREEN_ROWS + 7) / 8) * SCREEN_COLUMNS;
   localparam int ADDR_WIDTH     = $clog2(STORE_BYTES);
   localparam int GLYPH_BITS     = GLYPH_WIDTH * GLYPH_HEIGHT;
   localparam int GLYPH_IDX_W    = $clog2(GLYPH_BITS);
   localparam int GX_WIDTH       = $clog2(GLYPH_WIDTH);
   localparam int GY_WIDTH       = $clog2(GLYPH_HEIGHT);
   // worst case pixel address: page 31 of a 256-row space plus column 255
   localparam int PIX_ADDR_WIDTH = $clog2(32 * SCREEN_COLUMNS + 256);

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_PIXEL  = 3'd1,
      CMD_GLYPH  = 3'd2,
      CMD_CURSOR = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [ADDR_WIDTH-1:0] addr;
      logic [7:0]            wr_data;
   } store_req_type;

   function automatic logic [PIX_ADDR_WIDTH-1:0] pixel_addr(input logic [7:0] x,
                                                            input logic [7:0] y);
      return PIX_ADDR_WIDTH'(y[7:3]) * PIX_ADDR_WIDTH'(SCREEN_COLUMNS)
             + PIX_ADDR_WIDTH'(x);
   endfunction

endpackage

`default_nettype wire

/* design/lcdfb_if.sv */
// Request, response and control register channel interfaces.
`default_nettype none

interface lcdfb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [7:0]  pos_x;
   logic [7:0]  pos_y;
   logic        pixel_value;
   logic [34:0] glyph;
   logic [8:0]  byte_index;

   modport source(output valid, cmd, pos_x, pos_y, pixel_value, glyph, byte_index,
                  input ready);
   modport sink(input valid, cmd, pos_x, pos_y, pixel_value, glyph, byte_index,
                output ready);
endinterface

interface lcdfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] cursor_col;
   logic [7:0] cursor_row;

   modport source(output valid, read_data, cursor_col, cursor_row, input ready);
   modport sink(input valid, read_data, cursor_col, cursor_row, output ready);
endinterface

interface lcdfb_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] text_scale;

   modport source(output valid, text_scale, input ready);
   modport sink(input valid, text_scale, output ready);
endinterface

`default_nettype wire

/* design/lcdfb_frame_store.sv */
// Single-port frame store, one byte per page column, registered read data.
`default_nettype none

module lcdfb_frame_store (
   input  wire                         clock,
   input  lcdfb_pkg::store_req_type    store_req,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem [lcdfb_pkg::STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/lcd_framebuffer_text_engine.sv */
// Top level: command sequencer driving the frame store read-modify-write unit.
// A request is taken only in the idle state and is carried through to its response before the
// next is taken; each pixel is a store read then a store write.
// A new request is taken while the previous response is still waiting.
// Reset: synchronous; a sweep zeroes all 504 store bytes, req_if.ready stays low until done.
`default_nettype none

module lcd_framebuffer_text_engine (
   input  wire          clock,
   input  wire          reset,
   lcdfb_req_if.sink    req_if,
   lcdfb_rsp_if.source  rsp_if,
   lcdfb_csr_if.sink    csr_if
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_ADVANCE,
      ST_READ_CAP,
      ST_FINISH
   } state_type;

   localparam int AW = lcdfb_pkg::ADDR_WIDTH;
   localparam int XW = lcdfb_pkg::GX_WIDTH;
   localparam int YW = lcdfb_pkg::GY_WIDTH;
   localparam int IW = lcdfb_pkg::GLYPH_IDX_W;

   state_type                 state_ff, state_in;
   logic [AW-1:0]             sweep_ff, sweep_in;
   logic [7:0]                x_ff, x_in;
   logic [7:0]                y_ff, y_in;
   logic [XW-1:0]             gx_ff, gx_in;
   logic [3:0]                sx_ff, sx_in;
   logic [YW-1:0]             gy_ff, gy_in;
   logic [3:0]                sy_ff, sy_in;
   logic                      is_glyph_ff, is_glyph_in;
   logic                      value_ff, value_in;
   logic [34:0]               glyph_ff, glyph_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic                      in_range_ff, in_range_in;
   logic [7:0]                cur_col_ff, cur_col_in;
   logic [7:0]                cur_row_ff, cur_row_in;
   logic [7:0]                result_ff, result_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;
   logic [7:0]                rsp_col_ff, rsp_col_in;
   logic [7:0]                rsp_row_ff, rsp_row_in;
   logic [3:0]                scale_ff, scale_in;

   lcdfb_pkg::store_req_type  store_req;
   logic [7:0]                rd_data;

   logic [lcdfb_pkg::PIX_ADDR_WIDTH-1:0] pix_addr;
   logic                      pix_in_range;
   logic [IW-1:0]             glyph_pos;
   logic                      bit_on;
   logic [7:0]                bit_mask;
   logic [7:0]                modified;
   logic                      last_sx, last_gx, last_sy, last_gy;
   logic [7:0]                col_sum, row_sum, adv_row;
   logic                      req_accept;
   logic                      read_ok;

   lcdfb_frame_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_data  = rsp_data_ff;
   assign rsp_if.cursor_col = rsp_col_ff;
   assign rsp_if.cursor_row = rsp_row_ff;

   // pixel address unit, shared by set pixel and glyph drawing
   assign pix_addr     = lcdfb_pkg::pixel_addr(x_ff, y_ff);
   assign pix_in_range = pix_addr < lcdfb_pkg::PIX_ADDR_WIDTH'(lcdfb_pkg::STORE_BYTES);
   assign glyph_pos    = IW'(gx_ff) * IW'(lcdfb_pkg::GLYPH_HEIGHT) + IW'(gy_ff);
   assign bit_on       = is_glyph_ff ? glyph_ff[glyph_pos] : value_ff;
   assign bit_mask     = 8'd1 << y_ff[2:0];
   assign modified     = bit_on ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
   assign read_ok      = req_if.byte_index < 9'(lcdfb_pkg::STORE_BYTES);

   assign last_sx = (sx_ff == scale_ff - 4'd1);
   assign last_sy = (sy_ff == scale_ff - 4'd1);
   assign last_gx = (gx_ff == XW'(lcdfb_pkg::GLYPH_WIDTH - 1));
   assign last_gy = (gy_ff == YW'(lcdfb_pkg::GLYPH_HEIGHT - 1));

   // cursor advance, 8-bit wrap
   assign col_sum = cur_col_ff + 8'(scale_ff) * 8'(lcdfb_pkg::GLYPH_WIDTH) + 8'd1;
   assign row_sum = cur_row_ff + 8'(scale_ff) * 8'(lcdfb_pkg::GLYPH_HEIGHT) + 8'd1;
   assign adv_row = (col_sum >= 8'(lcdfb_pkg::SCREEN_COLUMNS)) ? row_sum : cur_row_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      gx_in        = gx_ff;
      sx_in        = sx_ff;
      gy_in        = gy_ff;
      sy_in        = sy_ff;
      is_glyph_in  = is_glyph_ff;
      value_in     = value_ff;
      glyph_in     = glyph_ff;
      addr_in      = addr_ff;
      in_range_in  = in_range_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      scale_in     = csr_if.valid ? csr_if.text_scale : scale_ff;

      store_req.rd_en   = 1'b0;
      store_req.wr_en   = 1'b0;
      store_req.addr    = addr_ff;
      store_req.wr_data = modified;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            store_req.wr_en   = 1'b1;
            store_req.addr    = sweep_ff;
            store_req.wr_data = 8'd0;
            sweep_in          = sweep_ff + AW'(1);
            if (sweep_ff == AW'(lcdfb_pkg::STORE_BYTES - 1)) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_FINISH;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               result_in = 8'd0;
               case (req_if.cmd)
                  lcdfb_pkg::CMD_CLEAR: begin
                     sweep_in   = '0;
                     cur_col_in = 8'd0;
                     cur_row_in = 8'd0;
                     state_in   = ST_CLEAR;
                  end
                  lcdfb_pkg::CMD_PIXEL: begin
                     x_in        = req_if.pos_x;
                     y_in        = req_if.pos_y;
                     value_in    = req_if.pixel_value;
                     is_glyph_in = 1'b0;
                     state_in    = ST_PIX_RD;
                  end
                  lcdfb_pkg::CMD_GLYPH: begin
                     glyph_in    = req_if.glyph;
                     is_glyph_in = 1'b1;
                     x_in        = cur_col_ff;
                     y_in        = cur_row_ff;
                     gx_in       = '0;
                     sx_in       = 4'd0;
                     gy_in       = '0;
                     sy_in       = 4'd0;
                     // zero scale draws nothing but still moves the cursor
                     state_in    = (scale_ff == 4'd0) ? ST_ADVANCE : ST_PIX_RD;
                  end
                  lcdfb_pkg::CMD_CURSOR: begin
                     cur_col_in = req_if.pos_x;
                     cur_row_in = req_if.pos_y;
                     state_in   = ST_FINISH;
                  end
                  lcdfb_pkg::CMD_READ: begin
                     store_req.rd_en = read_ok;
                     store_req.addr  = req_if.byte_index;
                     in_range_in     = read_ok;
                     state_in        = ST_READ_CAP;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PIX_RD: begin
            store_req.rd_en = pix_in_range;
            store_req.addr  = pix_addr[AW-1:0];
            addr_in         = pix_addr[AW-1:0];
            in_range_in     = pix_in_range;
            state_in        = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            store_req.wr_en = in_range_ff;
            if (!is_glyph_ff) begin
               state_in = ST_FINISH;
            end else if (!(last_sy && last_gy)) begin
               // rows inner
               y_in     = y_ff + 8'd1;
               sy_in    = last_sy ? 4'd0 : sy_ff + 4'd1;
               gy_in    = last_sy ? gy_ff + YW'(1) : gy_ff;
               state_in = ST_PIX_RD;
            end else begin
               y_in     = cur_row_ff;
               sy_in    = 4'd0;
               gy_in    = '0;
               x_in     = x_ff + 8'd1;
               sx_in    = last_sx ? 4'd0 : sx_ff + 4'd1;
               gx_in    = last_sx ? gx_ff + XW'(1) : gx_ff;
               state_in = (last_sx && last_gx) ? ST_ADVANCE : ST_PIX_RD;
            end
         end
         ST_ADVANCE: begin
            if (adv_row >= 8'(lcdfb_pkg::SCREEN_ROWS)) begin
               cur_col_in = 8'd0;
               cur_row_in = 8'd0;
            end else begin
               cur_col_in = (col_sum >= 8'(lcdfb_pkg::SCREEN_COLUMNS)) ? 8'd0 : col_sum;
               cur_row_in = adv_row;
            end
            state_in = ST_FINISH;
         end
         ST_READ_CAP: begin
            result_in = in_range_ff ? rd_data : 8'd0;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         cur_col_ff   <= 8'd0;
         cur_row_ff   <= 8'd0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= 4'd1;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_ff     <= scale_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      gx_ff       <= gx_in;
      sx_ff       <= sx_in;
      gy_ff       <= gy_in;
      sy_ff       <= sy_in;
      is_glyph_ff <= is_glyph_in;
      value_ff    <= value_in;
      glyph_ff    <= glyph_in;
      addr_ff     <= addr_in;
      in_range_ff <= in_range_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   // store never sees an address past the end, and never a read and write together
   a_store_addr: assert property (@(posedge clock) disable iff (reset)
      (store_req.wr_en || store_req.rd_en) |->
         (store_req.addr < AW'(lcdfb_pkg::STORE_BYTES)))
      else $error("frame store access out of range");

   a_store_port: assert property (@(posedge clock) disable iff (reset)
      !(store_req.wr_en && store_req.rd_en))
      else $error("frame store read and write in one cycle");

   // after a glyph the cursor always sits on the screen
   a_cursor_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADVANCE) |=>
         (cur_col_ff < 8'(lcdfb_pkg::SCREEN_COLUMNS)) &&
         (cur_row_ff < 8'(lcdfb_pkg::SCREEN_ROWS)))
      else $error("cursor off screen after glyph advance");

   // a response is only loaded from the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish step");

endmodule

`default_nettype wire

/* dv/lcd_framebuffer_text_engine_test.sv */
// Self-checking testbench for the framebuffer text engine: directed table, then random phases.
`timescale 1ns / 100ps

module lcd_framebuffer_text_engine_test;

   localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
   localparam logic [34:0] GLYPH_SOLID   = '1;
   localparam int          NUM_PHASES    = 7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  pos_x;
      logic [7:0]  pos_y;
      logic        pixel_value;
      logic [34:0] glyph;
      logic [8:0]  byte_index;
   } screen_cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
   } screen_rsp_type;

   // fixed: response typed in by hand rather than taken from the mirror
   typedef struct packed {
      bit             fixed;
      screen_rsp_type rsp;
   } known_answer_type;

   typedef struct packed {
      screen_cmd_type cmd;
      bit             fixed;
      screen_rsp_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;

   lcdfb_req_if req_bus();
   lcdfb_rsp_if rsp_bus();
   lcdfb_csr_if csr_bus();

   lcd_framebuffer_text_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // mirror of the block state
   logic [7:0] frame_mirror [lcdfb_pkg::STORE_BYTES];
   logic [7:0] mirror_col;
   logic [7:0] mirror_row;
   logic [3:0] mirror_scale;

   known_answer_type answer_book [$];
   screen_rsp_type   due_responses [$];
   int               cmds_issued;
   int               rsps_matched;
   int               stall_left;
   bit               failed;
   bit               quiet;

   logic [3:0] phase_scale [NUM_PHASES] = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd5};
   int         phase_items [NUM_PHASES] = '{550, 150, 12, 800, 30, 300, 120};

   directed_row_type directed_rows [26] = '{
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd511}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_PIXEL, 8'd0, 8'd0, 1'b1, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd1, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_PIXEL, 8'd83, 8'd47, 1'b1, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd503}, 1'b1, '{8'h80, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_PIXEL, 8'd0, 8'd48, 1'b1, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_PIXEL, 8'd255, 8'd255, 1'b1, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd504}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_PIXEL, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_GLYPH, 8'd0, 8'd0, 1'b0, GLYPH_SOLID, 9'd0}, 1'b1, '{8'd0, 8'd6, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_CURSOR, 8'd78, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd78, 8'd0}},
      '{'{lcdfb_pkg::CMD_GLYPH, 8'd0, 8'd0, 1'b0, 35'h5_5555_5555, 9'd0}, 1'b1,
        '{8'd0, 8'd0, 8'd8}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd78}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_CURSOR, 8'd80, 8'd45, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd80, 8'd45}},
      '{'{lcdfb_pkg::CMD_GLYPH, 8'd0, 8'd0, 1'b0, GLYPH_SOLID, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd503}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_CURSOR, 8'd255, 8'd255, 1'b0, 35'd0, 9'd0}, 1'b1,
        '{8'd0, 8'd255, 8'd255}},
      '{'{lcdfb_pkg::CMD_GLYPH, 8'd0, 8'd0, 1'b0, 35'h1_2345_6789, 9'd0}, 1'b1,
        '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{CMD_UNUSED_LO, 8'd255, 8'd255, 1'b1, GLYPH_SOLID, 9'd511}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{CMD_UNUSED_HI, 8'd7, 8'd9, 1'b1, GLYPH_SOLID, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{lcdfb_pkg::CMD_READ, 8'd0, 8'd0, 1'b0, 35'd0, 9'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}}
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void store_pixel(input int unsigned x, input int unsigned y, input bit on);
      int unsigned addr;
      addr = (y >> 3) * lcdfb_pkg::SCREEN_COLUMNS + x;
      if (addr < lcdfb_pkg::STORE_BYTES) frame_mirror[addr][y & 7] = on;
   endfunction

   function automatic screen_rsp_type apply_command(input screen_cmd_type c);
      screen_rsp_type res;
      int unsigned s, w, h, gx, gy;
      res = '0;
      case (c.cmd)
         lcdfb_pkg::CMD_CLEAR: begin
            foreach (frame_mirror[i]) frame_mirror[i] = 8'd0;
            mirror_col = 8'd0;
            mirror_row = 8'd0;
         end
         lcdfb_pkg::CMD_PIXEL: store_pixel(c.pos_x, c.pos_y, c.pixel_value);
         lcdfb_pkg::CMD_GLYPH: begin
            s = mirror_scale;
            w = lcdfb_pkg::GLYPH_WIDTH * s;
            h = lcdfb_pkg::GLYPH_HEIGHT * s;
            // column outer, row inner: later writes win on shared bits
            for (gx = 0; gx < w; gx++)
               for (gy = 0; gy < h; gy++)
                  store_pixel((mirror_col + gx) & 8'hFF, (mirror_row + gy) & 8'hFF,
                              c.glyph[(gx / s) * lcdfb_pkg::GLYPH_HEIGHT + gy / s]);
            mirror_col = 8'(mirror_col + w + 1);
            if (mirror_col >= lcdfb_pkg::SCREEN_COLUMNS) begin
               mirror_col = 8'd0;
               mirror_row = 8'(mirror_row + h + 1);
            end
            if (mirror_row >= lcdfb_pkg::SCREEN_ROWS) begin
               mirror_col = 8'd0;
               mirror_row = 8'd0;
            end
         end
         lcdfb_pkg::CMD_CURSOR: begin
            mirror_col = c.pos_x;
            mirror_row = c.pos_y;
         end
         lcdfb_pkg::CMD_READ:
            if (c.byte_index < lcdfb_pkg::STORE_BYTES)
               res.read_data = frame_mirror[c.byte_index];
         default: ;
      endcase
      res.cursor_col = mirror_col;
      res.cursor_row = mirror_row;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endtask

   task automatic issue_request(input screen_cmd_type c, input bit fixed,
                                input screen_rsp_type want);
      int gap;
      answer_book.push_back(known_answer_type'{fixed, want});
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= c.cmd;
      req_bus.pos_x       <= c.pos_x;
      req_bus.pos_y       <= c.pos_y;
      req_bus.pixel_value <= c.pixel_value;
      req_bus.glyph       <= c.glyph;
      req_bus.byte_index  <= c.byte_index;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      cmds_issued++;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off new requests until every response is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (rsps_matched != cmds_issued) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_text_scale(input logic [3:0] value);
      drain();
      csr_bus.valid      <= 1'b1;
      csr_bus.text_scale <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
   endtask

   // request/response/register monitor and response-side stalls
   always @(posedge clock) begin : watch
      screen_cmd_type   seen;
      screen_rsp_type   want;
      known_answer_type note;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) mirror_scale = csr_bus.text_scale;
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            seen = '{req_bus.cmd, req_bus.pos_x, req_bus.pos_y, req_bus.pixel_value,
                     req_bus.glyph, req_bus.byte_index};
            want = apply_command(seen);
            note = answer_book.pop_front();
            due_responses.push_back(note.fixed ? note.rsp : want);
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (due_responses.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               want = due_responses.pop_front();
               check_field("read_data", want.read_data, rsp_bus.read_data);
               check_field("cursor_col", want.cursor_col, rsp_bus.cursor_col);
               check_field("cursor_row", want.cursor_row, rsp_bus.cursor_row);
               rsps_matched++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      screen_cmd_type c;
      int pick;
      clock = 1'b0;
      reset <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.cmd         <= lcdfb_pkg::CMD_CLEAR;
      req_bus.pos_x       <= 8'd0;
      req_bus.pos_y       <= 8'd0;
      req_bus.pixel_value <= 1'b0;
      req_bus.glyph       <= '0;
      req_bus.byte_index  <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.text_scale  <= 4'd0;
      foreach (frame_mirror[i]) frame_mirror[i] = 8'd0;
      mirror_col   = 8'd0;
      mirror_row   = 8'd0;
      mirror_scale = 4'd1;
      cmds_issued  = 0;
      rsps_matched = 0;
      stall_left   = 0;
      failed       = 1'b0;
      quiet        = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         issue_request(directed_rows[k].cmd, directed_rows[k].fixed, directed_rows[k].rsp);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_text_scale(phase_scale[p]);
         for (int i = 0; i < phase_items[p]; i++) begin
            if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 199) == 0) drain();
            c.pos_x       = 8'($urandom);
            c.pos_y       = 8'($urandom);
            c.pixel_value = 1'($urandom);
            c.glyph       = 35'({$urandom, $urandom});
            c.byte_index  = 9'($urandom);
            pick = $urandom_range(0, 99);
            // open each phase with a glyph so every scale gets at least one glyph command
            if (i == 0 || pick < 25) begin
               c.cmd = lcdfb_pkg::CMD_GLYPH;
            end else if (pick < 27) begin
               c.cmd = lcdfb_pkg::CMD_CLEAR;
            end else if (pick < 57) begin
               c.cmd = lcdfb_pkg::CMD_PIXEL;
               if ($urandom_range(0, 99) < 85) begin
                  c.pos_x = 8'($urandom_range(0, lcdfb_pkg::SCREEN_COLUMNS - 1));
                  c.pos_y = 8'($urandom_range(0, lcdfb_pkg::SCREEN_ROWS - 1));
               end
            end else if (pick < 70) begin
               c.cmd = lcdfb_pkg::CMD_CURSOR;
               if ($urandom_range(0, 99) < 80) begin
                  c.pos_x = 8'($urandom_range(0, lcdfb_pkg::SCREEN_COLUMNS - 1));
                  c.pos_y = 8'($urandom_range(0, lcdfb_pkg::SCREEN_ROWS - 1));
               end
            end else if (pick < 95) begin
               c.cmd = lcdfb_pkg::CMD_READ;
               if ($urandom_range(0, 99) < 90)
                  c.byte_index = 9'($urandom_range(0, lcdfb_pkg::STORE_BYTES - 1));
            end else begin
               c.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            end
            issue_request(c, 1'b0, '0);
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (due_responses.size() != 0) begin
         $error("%0d responses never arrived", due_responses.size());
         failed = 1'b1;
      end
      if (!failed)
         $display("lcd_framebuffer_text_engine_test: PASS");
      else
         $display("lcd_framebuffer_text_engine_test: FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("lcd_framebuffer_text_engine_test: FAIL");
      $finish;
   end

endmodule
